FILE: design/src_pkg.sv
// ----------------------------------------------------------------------------
// Sensor reading converter package
// Result kinds, value selection codes and the side-band record that travels
// beside the long arithmetic units of the pipeline.
// ----------------------------------------------------------------------------
package src_pkg;

   localparam int CountW = 32;

   // Result kinds as seen on the result channel.
   localparam logic [2:0] KIND_TEMP = 3'd0;
   localparam logic [2:0] KIND_FLOW = 3'd1;
   localparam logic [2:0] KIND_PRES = 3'd2;
   localparam logic [2:0] KIND_CELS = 3'd3;
   localparam logic [2:0] KIND_NONE = 3'd4;

   // Source of the engineering value.
   localparam logic [1:0] VSEL_ZERO = 2'd0;
   localparam logic [1:0] VSEL_LIN  = 2'd1;
   localparam logic [1:0] VSEL_PT   = 2'd2;

   // Root extraction: two result bits per stage, 32 result bits.
   localparam int SqrtStages = 16;
   // Width of the PT100 quotient above 100 ohm.
   localparam int QuotW = 28;

   typedef struct packed {
      logic signed [CountW-1:0] counts;
      logic [2:0]               kind;
      logic [1:0]               vsel;
      logic signed [31:0]       lin;
      logic                     pt_root;
      logic                     pt_bad;
      logic signed [31:0]       poly;
      logic                     poly_inv;
   } side_type;

endpackage

FILE: design/sensor_reading_converter.sv
// ----------------------------------------------------------------------------
// Sensor reading converter
// Turns one converter result word into a signed count and a Q16.16
// engineering value: flow, pressure or PT100 temperature.
// ----------------------------------------------------------------------------
// A reading is taken every clock cycle while the result side does not stall.
// Its result passes four front stages, a 16-stage square root that yields two
// bits per stage, an 8-stage divide by a constant whose first stage forms the
// numerator and whose later stages each yield one 4-bit digit, and the output
// register. Every reading takes the same path, so results leave in order, and
// a stall on the result side holds the whole pipeline in place.
module sensor_reading_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // raw_word
   input  logic [4:0]  req_tuser,   // command, adc_select, channel[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // counts[31:0], value[31:0]
   output logic [3:0]  rsp_tuser    // kind[2:0], invalid
);
   import src_pkg::*;

   logic               adv;
   logic               f_valid, s_valid, d_valid;
   side_type           f_side, s_side, m_side, d_side;
   logic [61:0]        f_x;
   logic signed [30:0] f_r;
   logic               f_rlow;
   logic [30:0]        s_root;
   logic signed [31:0] p_val;
   logic               p_inv;
   logic [QuotW-1:0]   d_quot;
   logic signed [31:0] value_in;
   logic               inv_in;
   logic               rsp_tvalid_ff;
   logic [63:0]        rsp_tdata_ff;
   logic [3:0]         rsp_tuser_ff;

   // The pipeline moves whenever the output register is free or being drained.
   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;

   src_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .in_cmd    (req_tuser[0]),
      .in_adc    (req_tuser[1]),
      .in_ch     (req_tuser[4:2]),
      .in_raw    (req_tdata),
      .out_valid (f_valid),
      .out_side  (f_side),
      .out_x     (f_x),
      .out_r     (f_r),
      .out_rlow  (f_rlow)
   );

   src_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (f_valid),
      .in_side   (f_side),
      .in_x      (f_x),
      .out_valid (s_valid),
      .out_side  (s_side),
      .out_root  (s_root)
   );

   src_poly u_poly (
      .clock   (clock),
      .adv     (adv),
      .in_r    (f_r),
      .in_rlow (f_rlow),
      .out_val (p_val),
      .out_inv (p_inv)
   );

   always_comb begin
      m_side          = s_side;
      m_side.poly     = p_val;
      m_side.poly_inv = p_inv;
   end

   src_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s_valid),
      .in_side   (m_side),
      .in_root   (s_root),
      .out_valid (d_valid),
      .out_side  (d_side),
      .out_quot  (d_quot)
   );

   always_comb begin
      value_in = 32'sd0;
      inv_in   = 1'b0;
      unique case (d_side.vsel)
         VSEL_LIN: begin
            value_in = d_side.lin;
         end
         VSEL_PT: begin
            if (d_side.pt_root) begin
               value_in = d_side.pt_bad ? 32'sd0 : $signed(32'(d_quot));
               inv_in   = d_side.pt_bad;
            end else begin
               value_in = d_side.poly;
               inv_in   = d_side.poly_inv;
            end
         end
         default: begin
            value_in = 32'sd0;
            inv_in   = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         rsp_tvalid_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_tdata_ff <= {value_in, d_side.counts};
         rsp_tuser_ff <= {inv_in, d_side.kind};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   a_none_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[2:0] == KIND_NONE) |-> (rsp_tdata[63:32] == 32'd0) && !rsp_tuser[3])
      else $error("unused channel transfer carries a value or an invalid flag");

   a_temp_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[2:0] == KIND_TEMP) |-> (rsp_tdata[63:32] == 32'd0) && !rsp_tuser[3])
      else $error("temperature command transfer carries a value or an invalid flag");

   a_inv_cels : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[3] |-> (rsp_tuser[2:0] == KIND_CELS))
      else $error("invalid flag set on a result that is not a PT100 temperature");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input accepted while the output register is stalled");

endmodule

FILE: design/src_front.sv
// ----------------------------------------------------------------------------
// Sensor reading converter front end
// Four register stages: decode and constant products, offsets and rounding
// shifts, resistance products, and the discriminant for the root unit.
// ----------------------------------------------------------------------------
module src_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  logic                 in_cmd,
   input  logic                 in_adc,
   input  logic [2:0]           in_ch,
   input  logic [31:0]          in_raw,
   output logic                 out_valid,
   output src_pkg::side_type    out_side,
   output logic [61:0]          out_x,
   output logic signed [30:0]   out_r,
   output logic                 out_rlow
);
   import src_pkg::*;

   localparam logic [2:0] LIN_FLOW_DIV = 3'd0;
   localparam logic [2:0] LIN_FLOW     = 3'd1;
   localparam logic [2:0] LIN_PRES_LO  = 3'd2;
   localparam logic [2:0] LIN_PRES_HI  = 3'd3;
   localparam logic [2:0] LIN_LOOP     = 3'd4;
   localparam logic [2:0] LIN_DIVIDED  = 3'd5;

   localparam logic [63:0] DnBase = 64'd152726203204 << 21;

   function automatic logic signed [12:0] lin_k(input logic [2:0] s);
      logic signed [12:0] k;
      unique case (s)
         LIN_FLOW_DIV: k = 13'sd24;
         LIN_FLOW:     k = 13'sd60;
         LIN_PRES_LO:  k = 13'sd42;
         LIN_PRES_HI:  k = 13'sd360;
         LIN_LOOP:     k = 13'sd3750;
         LIN_DIVIDED:  k = 13'sd450;
         default:      k = 13'sd0;
      endcase
      return k;
   endfunction

   function automatic logic signed [47:0] lin_b(input logic [2:0] s);
      logic signed [47:0] b;
      unique case (s)
         LIN_FLOW_DIV: b = 48'sd163840;
         LIN_FLOW:     b = 48'sd32768;
         LIN_PRES_LO:  b = 48'sd65536;
         LIN_PRES_HI:  b = 48'sd32768;
         LIN_LOOP:     b = -48'sd214748332032;
         LIN_DIVIDED:  b = -48'sd25769541632;
         default:      b = 48'sd0;
      endcase
      return b;
   endfunction

   function automatic logic [4:0] lin_s(input logic [2:0] s);
      logic [4:0] sh;
      unique case (s)
         LIN_PRES_LO: sh = 5'd17;
         LIN_DIVIDED: sh = 5'd19;
         default:     sh = 5'd16;
      endcase
      return sh;
   endfunction

   // Stage 1
   logic signed [31:0] c_in, cadj_in, counts1_in;
   logic [2:0]         kind1_in, lsel1_in;
   logic [1:0]         vsel1_in;
   logic signed [43:0] p3125_1_in;
   logic signed [44:0] plin1_in;
   logic               v1_ff;
   logic signed [31:0] counts1_ff;
   logic [2:0]         kind1_ff, lsel1_ff;
   logic [1:0]         vsel1_ff;
   logic signed [43:0] p3125_1_ff;
   logic signed [44:0] plin1_ff;

   // Stage 2
   logic signed [44:0] m_in;
   logic signed [45:0] rnum_in, rfull_in;
   logic signed [47:0] lsum_in;
   logic               v2_ff, mneg2_ff, mbig2_ff, rlow2_ff, f0_2_ff;
   logic signed [31:0] counts2_ff, lsum2_ff;
   logic [2:0]         kind2_ff;
   logic [1:0]         vsel2_ff;
   logic [38:0]        m2_ff;
   logic signed [30:0] r2_ff;

   // Stage 3
   logic [22:0]        tp_in;
   logic               v3_ff, mneg3_ff, mbig3_ff, rlow3_ff, f0_3_ff;
   logic signed [31:0] counts3_ff, lsum3_ff;
   logic [2:0]         kind3_ff;
   logic [1:0]         vsel3_ff;
   logic [40:0]        pplo3_ff;
   logic [39:0]        pphi3_ff;
   logic [46:0]        ldiv3_ff;
   logic signed [30:0] r3_ff;

   // Stage 4
   logic [63:0]        prodm_in;
   logic signed [63:0] dn_in;
   side_type           side4_in;
   logic               v4_ff, rlow4_ff;
   side_type           side4_ff;
   logic [61:0]        x4_ff;
   logic signed [30:0] r4_ff;

   // The received word with its top bit flipped is the signed count; a temperature command reports it divided by 128.
   assign c_in    = {~in_raw[31], in_raw[30:0]};
   assign cadj_in = c_in + (c_in[31] ? 32'sd127 : 32'sd0);

   always_comb begin
      kind1_in = KIND_NONE;
      vsel1_in = VSEL_ZERO;
      lsel1_in = LIN_FLOW;
      if (!in_cmd) begin
         kind1_in = KIND_TEMP;
      end else if (!in_adc) begin
         unique case (in_ch)
            3'd0: begin
               kind1_in = KIND_FLOW; vsel1_in = VSEL_LIN; lsel1_in = LIN_FLOW_DIV;
            end
            3'd1, 3'd2: begin
               kind1_in = KIND_FLOW; vsel1_in = VSEL_LIN; lsel1_in = LIN_FLOW;
            end
            3'd3, 3'd4: begin
               kind1_in = KIND_PRES; vsel1_in = VSEL_LIN; lsel1_in = LIN_PRES_LO;
            end
            3'd5: begin
               kind1_in = KIND_PRES; vsel1_in = VSEL_LIN; lsel1_in = LIN_PRES_HI;
            end
            default: begin
               kind1_in = KIND_CELS; vsel1_in = VSEL_PT;
            end
         endcase
      end else begin
         unique case (in_ch)
            3'd0: begin
               kind1_in = KIND_PRES; vsel1_in = VSEL_LIN; lsel1_in = LIN_LOOP;
            end
            3'd1, 3'd2: begin
               kind1_in = KIND_PRES; vsel1_in = VSEL_LIN; lsel1_in = LIN_DIVIDED;
            end
            3'd3: begin
               kind1_in = KIND_CELS; vsel1_in = VSEL_PT;
            end
            default: begin
               kind1_in = KIND_NONE; vsel1_in = VSEL_ZERO;
            end
         endcase
      end
   end

   assign counts1_in = in_cmd ? c_in : (cadj_in >>> 7);
   assign p3125_1_in = 44'(c_in) * 44'sd3125;
   assign plin1_in   = 45'(c_in) * 45'(lin_k(lsel1_in));

   // Stage 2 logic: resistance offset, rounded resistance, linear scaling.
   assign m_in     = 45'(p3125_1_ff) - 45'sd26843545600;
   assign rnum_in  = (46'(p3125_1_ff) <<< 1) + 46'sd256;
   assign rfull_in = rnum_in >>> 9;
   assign lsum_in  = (48'(plin1_ff) + lin_b(lsel1_ff)) >>> lin_s(lsel1_ff);

   // Stage 3 logic: the first flow channel still needs a division by five.
   assign tp_in = 23'(lsum2_ff + 32'sd5242880);

   // Stage 4 logic: discriminant of the PT100 quadratic.
   assign prodm_in = ({24'd0, pphi3_ff} << 20) + 64'(pplo3_ff);
   assign dn_in    = $signed(DnBase - prodm_in);

   always_comb begin
      side4_in          = '0;
      side4_in.counts   = counts3_ff;
      side4_in.kind     = kind3_ff;
      side4_in.vsel     = vsel3_ff;
      side4_in.lin      = f0_3_ff ? (32'(ldiv3_ff[46:26]) - 32'sd1048576) : lsum3_ff;
      side4_in.pt_root  = !mneg3_ff;
      side4_in.pt_bad   = mbig3_ff | dn_in[63];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         counts1_ff <= counts1_in;
         kind1_ff   <= kind1_in;
         vsel1_ff   <= vsel1_in;
         lsel1_ff   <= lsel1_in;
         p3125_1_ff <= p3125_1_in;
         plin1_ff   <= plin1_in;

         counts2_ff <= counts1_ff;
         kind2_ff   <= kind1_ff;
         vsel2_ff   <= vsel1_ff;
         f0_2_ff    <= (lsel1_ff == LIN_FLOW_DIV);
         m2_ff      <= m_in[38:0];
         mneg2_ff   <= m_in[44];
         mbig2_ff   <= !m_in[44] && (m_in > 45'sd274877906944);
         r2_ff      <= rfull_in[30:0];
         rlow2_ff   <= (rfull_in < -46'sd1073741824);
         lsum2_ff   <= lsum_in[31:0];

         counts3_ff <= counts2_ff;
         kind3_ff   <= kind2_ff;
         vsel3_ff   <= vsel2_ff;
         f0_3_ff    <= f0_2_ff;
         mneg3_ff   <= mneg2_ff;
         mbig3_ff   <= mbig2_ff;
         pplo3_ff   <= 41'(m2_ff[19:0]) * 41'd1813125;
         pphi3_ff   <= 40'(m2_ff[38:20]) * 40'd1813125;
         ldiv3_ff   <= 47'(tp_in) * 47'd13421773;
         lsum3_ff   <= lsum2_ff;
         r3_ff      <= r2_ff;
         rlow3_ff   <= rlow2_ff;

         side4_ff   <= side4_in;
         x4_ff      <= {dn_in[58:0], 3'b000};
         r4_ff      <= r3_ff;
         rlow4_ff   <= rlow3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign out_side  = side4_ff;
   assign out_x     = x4_ff;
   assign out_r     = r4_ff;
   assign out_rlow  = rlow4_ff;

endmodule

FILE: design/src_sqrt.sv
// ----------------------------------------------------------------------------
// Sensor reading converter root unit
// Pipelined integer square root, two result bits per stage, with the item's
// side-band record carried alongside.
// ----------------------------------------------------------------------------
module src_sqrt (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  src_pkg::side_type in_side,
   input  logic [61:0]       in_x,
   output logic              out_valid,
   output src_pkg::side_type out_side,
   output logic [30:0]       out_root
);
   import src_pkg::*;

   typedef struct packed {
      logic [63:0] rem;
      logic [63:0] res;
   } sq_type;

   function automatic sq_type sq_step(input sq_type a, input int unsigned k);
      sq_type      o;
      logic [63:0] bit_v;
      logic [63:0] trial;
      bit_v = 64'd1 << (2 * k);
      trial = a.res + bit_v;
      if (a.rem >= trial) begin
         o.rem = a.rem - trial;
         o.res = (a.res >> 1) + bit_v;
      end else begin
         o.rem = a.rem;
         o.res = a.res >> 1;
      end
      return o;
   endfunction

   logic [SqrtStages-1:0] vld_ff;
   side_type              side_ff [SqrtStages];
   sq_type                st_ff   [SqrtStages];
   sq_type                src_w   [SqrtStages];
   sq_type                st_in   [SqrtStages];

   always_comb begin
      for (int i = 0; i < SqrtStages; i++) begin
         if (i == 0) begin
            src_w[i] = {64'(in_x), 64'd0};
         end else begin
            src_w[i] = st_ff[i-1];
         end
         st_in[i] = sq_step(sq_step(src_w[i], 31 - 2 * i), 30 - 2 * i);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[SqrtStages-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= in_side;
         for (int i = 1; i < SqrtStages; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         for (int i = 0; i < SqrtStages; i++) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   assign out_valid = vld_ff[SqrtStages-1];
   assign out_side  = side_ff[SqrtStages-1];
   assign out_root  = st_ff[SqrtStages-1].res[30:0];

endmodule

FILE: design/src_poly.sv
// ----------------------------------------------------------------------------
// Sensor reading converter PT100 quintic
// Horner evaluation of the below-100-ohm polynomial, one multiply and one
// rescale stage per coefficient, padded to the latency of the root unit.
// ----------------------------------------------------------------------------
module src_poly (
   input  logic               clock,
   input  logic               adv,
   input  logic signed [30:0] in_r,
   input  logic               in_rlow,
   output logic signed [31:0] out_val,
   output logic               out_inv
);
   import src_pkg::*;

   localparam int PolyStages = 10;
   localparam int PolyPad    = SqrtStages - PolyStages;

   logic signed [30:0] rr_ff [8];
   logic               rl_ff [9];
   logic signed [66:0] mp_ff [5];
   logic signed [35:0] pv_ff [4];
   logic signed [39:0] p5_in;
   logic signed [31:0] val_in;
   logic               inv_in;
   logic signed [31:0] val_ff [PolyPad+1];
   logic               inv_ff [PolyPad+1];

   // Final rescale and saturation; a resistance far below range pins low.
   assign p5_in = 40'(mp_ff[4] >>> 29) - 40'sd15853158;

   always_comb begin
      if (rl_ff[8]) begin
         val_in = -32'sd2147483648;
         inv_in = 1'b1;
      end else if (p5_in > 40'sd2147483647) begin
         val_in = 32'sd2147483647;
         inv_in = 1'b1;
      end else if (p5_in < -40'sd2147483648) begin
         val_in = -32'sd2147483648;
         inv_in = 1'b1;
      end else begin
         val_in = p5_in[31:0];
         inv_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rr_ff[0] <= in_r;
         rl_ff[0] <= in_rlow;
         for (int i = 1; i < 8; i++) begin
            rr_ff[i] <= rr_ff[i-1];
         end
         for (int i = 1; i < 9; i++) begin
            rl_ff[i] <= rl_ff[i-1];
         end
         mp_ff[0] <= 67'(in_r) * 67'sd5753799;
         pv_ff[0] <= 36'(mp_ff[0] >>> 20) - 36'sd1063209800;
         mp_ff[1] <= 67'(pv_ff[0]) * 67'(rr_ff[1]);
         pv_ff[1] <= 36'(mp_ff[1] >>> 30) - 36'sd168322036;
         mp_ff[2] <= 67'(pv_ff[1]) * 67'(rr_ff[3]);
         pv_ff[2] <= 36'(mp_ff[2] >>> 30) + 36'sd89781996;
         mp_ff[3] <= 67'(pv_ff[2]) * 67'(rr_ff[5]);
         pv_ff[3] <= 36'(mp_ff[3] >>> 30) + 36'sd74457285;
         mp_ff[4] <= 67'(pv_ff[3]) * 67'(rr_ff[7]);
         val_ff[0] <= val_in;
         inv_ff[0] <= inv_in;
         for (int i = 1; i <= PolyPad; i++) begin
            val_ff[i] <= val_ff[i-1];
            inv_ff[i] <= inv_ff[i-1];
         end
      end
   end

   assign out_val = val_ff[PolyPad];
   assign out_inv = inv_ff[PolyPad];

endmodule

FILE: design/src_div.sv
// ----------------------------------------------------------------------------
// Sensor reading converter constant divider
// Forms the PT100 numerator from the root and divides it by 5802 with
// rounding folded in, one 4-bit quotient digit per stage after the first.
// ----------------------------------------------------------------------------
module src_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  src_pkg::side_type in_side,
   input  logic [30:0]       in_root,
   output logic              out_valid,
   output src_pkg::side_type out_side,
   output logic [src_pkg::QuotW-1:0] out_quot
);
   import src_pkg::*;

   localparam int Digits    = QuotW / 4;
   localparam int DivStages = Digits + 1;
   localparam int Divisor   = 5802;
   localparam int NumW      = QuotW + 13;

   typedef struct packed {
      logic [3:0]  digit;
      logic [12:0] rem;
   } dd_type;

   function automatic dd_type div_digit(input logic [16:0] v);
      dd_type     o;
      logic [3:0] dg;
      dg = 4'd0;
      for (int d = 1; d < 16; d++) begin
         if (v >= 17'(d * Divisor)) dg = 4'(d);
      end
      o.digit = dg;
      o.rem   = 13'(v - 17'(dg) * 17'(Divisor));
      return o;
   endfunction

   logic [DivStages-1:0] vld_ff;
   side_type             side_ff [DivStages];
   logic [NumW-1:0]      num_ff  [DivStages];
   logic [12:0]          rem_ff  [DivStages];
   logic [QuotW-1:0]     quot_ff [DivStages];
   logic [31:0]          diff_in;
   logic [NumW-1:0]      num0_in;
   dd_type               dd_in   [DivStages];

   // The numerator plus half the divisor, so that the floor rounds to nearest.
   assign diff_in = 32'd1600724992 - 32'(in_root);
   assign num0_in = NumW'(diff_in) * NumW'(800) + NumW'(2901);

   always_comb begin
      dd_in[0] = '0;
      for (int e = 1; e < DivStages; e++) begin
         dd_in[e] = div_digit({rem_ff[e-1], num_ff[e-1][4 * (Digits - e) +: 4]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DivStages-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= in_side;
         num_ff[0]  <= num0_in;
         rem_ff[0]  <= num0_in[NumW-1:QuotW];
         quot_ff[0] <= '0;
         for (int e = 1; e < DivStages; e++) begin
            side_ff[e] <= side_ff[e-1];
            num_ff[e]  <= num_ff[e-1];
            rem_ff[e]  <= dd_in[e].rem;
            quot_ff[e] <= {quot_ff[e-1][QuotW-5:0], dd_in[e].digit};
         end
      end
   end

   assign out_valid = vld_ff[DivStages-1];
   assign out_side  = side_ff[DivStages-1];
   assign out_quot  = quot_ff[DivStages-1];

endmodule
